@@ rtl/two_zone_direction_counter_core_assert.svh @@
// Assertion macros used by the direction counter path tracker.
`ifndef TWO_ZONE_DIRECTION_COUNTER_CORE_ASSERT_SVH
`define TWO_ZONE_DIRECTION_COUNTER_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TZDC_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define TZDC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/tzdc_pkg.sv @@
package tzdc_pkg;

    // Field widths
    localparam int DIST_W    = 16;
    localparam int TIME_W    = 32;
    localparam int REG_IDX_W = 3;
    localparam int CFG_W     = 32;
    localparam int FILL_W    = 3;

    // Register indexes on the configuration channel
    localparam logic [REG_IDX_W-1:0] REG_ENTRY_MIN = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_ENTRY_MAX = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_EXIT_MIN  = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_EXIT_MAX  = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_SWAP      = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_TIMEOUT   = 3'd5;

    // Event codes
    localparam logic [1:0] EV_NONE    = 2'd0;
    localparam logic [1:0] EV_ENTRY   = 2'd1;
    localparam logic [1:0] EV_EXIT    = 2'd2;
    localparam logic [1:0] EV_TIMEOUT = 2'd3;

    // Presence report codes
    localparam logic [1:0] PR_NONE    = 2'd0;
    localparam logic [1:0] PR_PRESENT = 2'd1;
    localparam logic [1:0] PR_EMPTY   = 2'd2;

    // Two-zone path codes
    localparam logic [1:0] CODE_LEFT  = 2'd1;
    localparam logic [1:0] CODE_RIGHT = 2'd2;
    localparam logic [1:0] CODE_BOTH  = 2'd3;

    // Fill level bounds
    localparam logic [FILL_W-1:0] FILL_EMPTY = 3'd1;
    localparam logic [FILL_W-1:0] FILL_SLOT2 = 3'd2;
    localparam logic [FILL_W-1:0] FILL_SLOT3 = 3'd3;
    localparam logic [FILL_W-1:0] FILL_FULL  = 3'd4;

    typedef struct packed {
        logic [DIST_W-1:0] entry_min_mm;
        logic [DIST_W-1:0] entry_max_mm;
        logic [DIST_W-1:0] exit_min_mm;
        logic [DIST_W-1:0] exit_max_mm;
        logic              swap_direction;
        logic [TIME_W-1:0] idle_timeout_ms;
    } cfg_t;

    typedef struct packed {
        logic              zone_sel;
        logic [DIST_W-1:0] distance_mm;
        logic [TIME_W-1:0] time_ms;
    } item_t;

    typedef struct packed {
        logic [1:0] event_code;
        logic [1:0] presence_report;
    } result_t;

endpackage

@@ rtl/tzdc_sample_if.sv @@
interface tzdc_sample_if
    import tzdc_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              zone_sel;
    logic [DIST_W-1:0] distance_mm;
    logic [TIME_W-1:0] time_ms;

    modport source (output valid, output zone_sel, output distance_mm, output time_ms,
                    input ready);
    modport sink   (input valid, input zone_sel, input distance_mm, input time_ms,
                    output ready);
endinterface

@@ rtl/tzdc_result_if.sv @@
interface tzdc_result_if;
    logic       valid;
    logic       ready;
    logic [1:0] event_code;
    logic [1:0] presence_report;

    modport source (output valid, output event_code, output presence_report, input ready);
    modport sink   (input valid, input event_code, input presence_report, output ready);
endinterface

@@ rtl/tzdc_cfg_if.sv @@
interface tzdc_cfg_if
    import tzdc_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [REG_IDX_W-1:0] reg_index;
    logic [CFG_W-1:0]     wdata;

    modport source (output valid, output reg_index, output wdata, input ready);
    modport sink   (input valid, input reg_index, input wdata, output ready);
endinterface

@@ rtl/tzdc_cfg_regs.sv @@
module tzdc_cfg_regs
    import tzdc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    tzdc_cfg_if.sink   cfg,
    output cfg_t       cfg_out
);

    cfg_t cfg_reg;

    // Writes are always taken; indexes beyond the list are ignored.
    assign cfg.ready = 1'b1;
    assign cfg_out   = cfg_reg;

    // Register file, loaded on each configuration transfer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.entry_min_mm    <= '0;
            cfg_reg.entry_max_mm    <= '1;
            cfg_reg.exit_min_mm     <= '0;
            cfg_reg.exit_max_mm     <= '1;
            cfg_reg.swap_direction  <= 1'b0;
            cfg_reg.idle_timeout_ms <= '0;
        end
        else if (cfg.valid)
        begin
            case (cfg.reg_index)
                REG_ENTRY_MIN: cfg_reg.entry_min_mm    <= cfg.wdata[DIST_W-1:0];
                REG_ENTRY_MAX: cfg_reg.entry_max_mm    <= cfg.wdata[DIST_W-1:0];
                REG_EXIT_MIN:  cfg_reg.exit_min_mm     <= cfg.wdata[DIST_W-1:0];
                REG_EXIT_MAX:  cfg_reg.exit_max_mm     <= cfg.wdata[DIST_W-1:0];
                REG_SWAP:      cfg_reg.swap_direction  <= cfg.wdata[0];
                REG_TIMEOUT:   cfg_reg.idle_timeout_ms <= cfg.wdata[TIME_W-1:0];
                default:       ;
            endcase
        end
    end

endmodule

@@ rtl/tzdc_path_tracker.sv @@
module tzdc_path_tracker
    import tzdc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  cfg_t    cfg,
    input  logic    advance,
    input  item_t   item,
    output result_t res
);

    `include "two_zone_direction_counter_core_assert.svh"

    logic [1:0]        hist_reg [1:3];
    logic [1:0]        hist_next [1:3];
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic              left_reg, left_next;
    logic              right_reg, right_next;
    logic [TIME_W-1:0] last_change_reg, last_change_next;

    logic [DIST_W-1:0] lo, hi;
    logic              occ;
    logic [TIME_W-1:0] elapsed;
    logic              timed_out;
    logic              is_left;
    logic              changed;
    logic              left_new, right_new;
    logic [1:0]        code;
    logic [FILL_W-1:0] fill_inc;
    logic              both_empty;
    logic              full_now;
    logic              match_exit, match_entry;

    // Occupancy of the sampled zone and idle timeout check.
    always_comb
    begin
        lo        = item.zone_sel ? cfg.exit_min_mm : cfg.entry_min_mm;
        hi        = item.zone_sel ? cfg.exit_max_mm : cfg.entry_max_mm;
        occ       = (item.distance_mm < hi) && (item.distance_mm > lo);
        elapsed   = item.time_ms - last_change_reg;
        timed_out = (fill_reg != FILL_EMPTY) && (cfg.idle_timeout_ms != '0)
                    && (elapsed > cfg.idle_timeout_ms);
    end

    // Occupancy change and the resulting two-zone code.
    always_comb
    begin
        is_left    = (item.zone_sel == cfg.swap_direction);
        changed    = is_left ? (occ != left_reg) : (occ != right_reg);
        left_new   = is_left ? occ : left_reg;
        right_new  = is_left ? right_reg : occ;
        code       = {right_new, left_new};
        fill_inc   = (fill_reg < FILL_FULL) ? fill_reg + FILL_W'(1) : fill_reg;
        both_empty = !left_new && !right_new;
        full_now   = (fill_inc == FILL_FULL);
        match_exit = (hist_reg[1] == CODE_LEFT) && (hist_reg[2] == CODE_BOTH)
                     && (hist_reg[3] == CODE_RIGHT);
        match_entry = (hist_reg[1] == CODE_RIGHT) && (hist_reg[2] == CODE_BOTH)
                      && (hist_reg[3] == CODE_LEFT);
    end

    // Next state and result.
    always_comb
    begin
        hist_next        = hist_reg;
        fill_next        = fill_reg;
        left_next        = left_reg;
        right_next       = right_reg;
        last_change_next = last_change_reg;
        res.event_code   = EV_NONE;
        res.presence_report = PR_NONE;

        if (timed_out)
        begin
            hist_next        = '{default: 2'd0};
            fill_next        = FILL_EMPTY;
            left_next        = 1'b0;
            right_next       = 1'b0;
            last_change_next = item.time_ms;
            res.event_code   = EV_TIMEOUT;
        end
        else
        begin
            if (changed)
            begin
                last_change_next = item.time_ms;
                if (both_empty)
                begin
                    if (full_now && match_exit)
                        res.event_code = EV_EXIT;
                    else if (full_now && match_entry)
                        res.event_code = EV_ENTRY;
                    hist_next  = '{default: 2'd0};
                    fill_next  = FILL_EMPTY;
                    left_next  = 1'b0;
                    right_next = 1'b0;
                end
                else
                begin
                    fill_next  = fill_inc;
                    left_next  = left_new;
                    right_next = right_new;
                    case (fill_inc)
                        FILL_SLOT2: hist_next[1] = code;
                        FILL_SLOT3: hist_next[2] = code;
                        default:    hist_next[3] = code;
                    endcase
                end
            end

            if (occ)
                res.presence_report = PR_PRESENT;
            else if (both_empty)
                res.presence_report = PR_EMPTY;
        end
    end

    // Path state, updated once per item.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hist_reg        <= '{default: 2'd0};
            fill_reg        <= FILL_EMPTY;
            left_reg        <= 1'b0;
            right_reg       <= 1'b0;
            last_change_reg <= '0;
        end
        else if (advance)
        begin
            hist_reg        <= hist_next;
            fill_reg        <= fill_next;
            left_reg        <= left_next;
            right_reg       <= right_next;
            last_change_reg <= last_change_next;
        end
    end

    // An empty path has a clear history and no occupied zone.
    `TZDC_ASSERT_SAME(a_empty_path_clear, clk, rst_n, fill_reg == FILL_EMPTY, (hist_reg[1] == 2'd0) && (hist_reg[2] == 2'd0) && (hist_reg[3] == 2'd0) && !left_reg && !right_reg, "empty path holds stale state")
    // A timeout or a completed crossing leaves the path cleared.
    `TZDC_ASSERT_NEXT(a_clear_after_event, clk, rst_n, advance && (res.event_code != EV_NONE), (fill_reg == FILL_EMPTY) && !left_reg && !right_reg, "path not cleared after event")
    // A timeout carries no presence report.
    `TZDC_ASSERT_SAME(a_timeout_no_presence, clk, rst_n, res.event_code == EV_TIMEOUT, res.presence_report == PR_NONE, "timeout with presence report")
    // The fill level stays within one to four.
    `TZDC_ASSERT_NEXT(a_fill_range, clk, rst_n, 1'b1, (fill_reg >= FILL_EMPTY) && (fill_reg <= FILL_FULL), "fill level out of range")

endmodule

@@ rtl/two_zone_direction_counter_core.sv @@
// A sample waits in the input register; its result then waits in the result register.
// Throughput: one sample per cycle unless result.ready is held low; the path state
// update is a single registered pass.
// An input register and a result register separate the two channels.
// Reset (rst_n, asynchronous, active low) empties both registers, clears the path
// history and occupancy, and restores all configuration registers to their defaults.
module two_zone_direction_counter_core
    import tzdc_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    tzdc_sample_if.sink   sample,
    tzdc_result_if.source result,
    tzdc_cfg_if.sink      cfg
);

    cfg_t    cfg_val;
    item_t   item_reg;
    logic    item_valid_reg, item_valid_next;
    result_t res_comb;
    result_t res_reg;
    logic    res_valid_reg, res_valid_next;
    logic    advance;
    logic    take_sample;

    // Configuration register file.
    tzdc_cfg_regs u_cfg_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .cfg_out (cfg_val)
    );

    // The held sample moves on when the result register is free or being emptied.
    assign advance         = item_valid_reg && (!res_valid_reg || result.ready);
    assign sample.ready    = !item_valid_reg || advance;
    assign take_sample     = sample.valid && sample.ready;
    assign item_valid_next = take_sample || (item_valid_reg && !advance);
    assign res_valid_next  = advance || (res_valid_reg && !result.ready);

    // Path tracking state and step logic.
    tzdc_path_tracker u_path_tracker (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_val),
        .advance (advance),
        .item    (item_reg),
        .res     (res_comb)
    );

    // Valid flags of the input and result registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            item_valid_reg <= item_valid_next;
            res_valid_reg  <= res_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (take_sample)
        begin
            item_reg.zone_sel    <= sample.zone_sel;
            item_reg.distance_mm <= sample.distance_mm;
            item_reg.time_ms     <= sample.time_ms;
        end
        if (advance)
            res_reg <= res_comb;
    end

    // Result channel.
    assign result.valid           = res_valid_reg;
    assign result.event_code      = res_reg.event_code;
    assign result.presence_report = res_reg.presence_report;

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 100ps

module tb;
    import tzdc_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 120;
    localparam int PHASE_ITEMS = 170;

    logic clk;
    logic rst_n;

    tzdc_sample_if sample_ch();
    tzdc_result_if result_ch();
    tzdc_cfg_if    cfg_ch();

    two_zone_direction_counter_core dut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (sample_ch.sink),
        .result (result_ch.source),
        .cfg    (cfg_ch.sink)
    );

    // Pending samples, and the reports the tracker expects back in order.
    item_t   sample_queue [$];
    result_t expected_reports [$];

    // Shadow of the configuration registers.
    cfg_t zone_cfg;

    // Shadow of the path tracking state.
    logic [1:0]        trail_codes [4];
    logic [FILL_W-1:0] trail_depth;
    logic              left_busy;
    logic              right_busy;
    logic [TIME_W-1:0] last_move_ms;

    // Stimulus time base and bookkeeping.
    logic [TIME_W-1:0] now_ms;
    int unsigned queued_count;
    int unsigned accepted_count;
    int unsigned checked_count;
    int unsigned failures;
    int unsigned cycle_count;
    int unsigned report_tally [4];
    int unsigned src_idle_pct;
    int unsigned dst_idle_pct;
    int unsigned hold_requests;
    int unsigned holds_served;
    int unsigned hold_left;

    // Clock with a 12 ns period.
    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // Every clear empties the trail and both zones and restarts the idle timer.
    function automatic void reset_trail(input logic [TIME_W-1:0] at_ms);
        for (int k = 0; k < 4; k++)
        begin
            trail_codes[k] = 2'b00;
        end
        trail_depth  = FILL_EMPTY;
        left_busy    = 1'b0;
        right_busy   = 1'b0;
        last_move_ms = at_ms;
    endfunction

    // Works out the report for one sample and advances the shadow state.
    function automatic result_t track_sample(input item_t smp);
        result_t           rep;
        logic [DIST_W-1:0] lo_mm;
        logic [DIST_W-1:0] hi_mm;
        logic [TIME_W-1:0] elapsed;
        logic              occ;
        logic              moved;
        logic [1:0]        code;
        rep.event_code      = EV_NONE;
        rep.presence_report = PR_NONE;
        elapsed = smp.time_ms - last_move_ms;

        // A stale partial path is dropped before the sample is looked at.
        if (trail_depth > FILL_EMPTY && zone_cfg.idle_timeout_ms != '0 &&
            elapsed > zone_cfg.idle_timeout_ms)
        begin
            reset_trail(smp.time_ms);
            rep.event_code = EV_TIMEOUT;
            return rep;
        end

        lo_mm = smp.zone_sel ? zone_cfg.exit_min_mm : zone_cfg.entry_min_mm;
        hi_mm = smp.zone_sel ? zone_cfg.exit_max_mm : zone_cfg.entry_max_mm;
        occ   = (smp.distance_mm > lo_mm) && (smp.distance_mm < hi_mm);
        if (occ)
        begin
            rep.presence_report = PR_PRESENT;
        end

        // The path code holds the left zone in bit 0 and the right zone in bit 1.
        moved = 1'b0;
        code  = 2'b00;
        if (smp.zone_sel == zone_cfg.swap_direction)
        begin
            if (occ != left_busy)
            begin
                moved     = 1'b1;
                code      = {right_busy, occ};
                left_busy = occ;
            end
        end
        else if (occ != right_busy)
        begin
            moved      = 1'b1;
            code       = {occ, left_busy};
            right_busy = occ;
        end

        if (moved)
        begin
            last_move_ms = smp.time_ms;
            if (trail_depth < FILL_FULL)
            begin
                trail_depth = trail_depth + 1'b1;
            end
            if (!left_busy && !right_busy)
            begin
                if (trail_depth == FILL_FULL)
                begin
                    if (trail_codes[1] == CODE_LEFT && trail_codes[2] == CODE_BOTH &&
                        trail_codes[3] == CODE_RIGHT)
                    begin
                        rep.event_code = EV_EXIT;
                    end
                    else if (trail_codes[1] == CODE_RIGHT && trail_codes[2] == CODE_BOTH &&
                             trail_codes[3] == CODE_LEFT)
                    begin
                        rep.event_code = EV_ENTRY;
                    end
                end
                reset_trail(smp.time_ms);
            end
            else
            begin
                trail_codes[2'(trail_depth - 1'b1)] = code;
            end
        end

        if (!occ && !left_busy && !right_busy)
        begin
            rep.presence_report = PR_EMPTY;
        end
        return rep;
    endfunction

    // Sample driver: records each transfer and offers the next pending sample.
    always @(posedge clk)
    begin : drive_samples
        item_t taken;
        if (rst_n)
        begin
            if (sample_ch.valid && sample_ch.ready)
            begin
                taken.zone_sel    = sample_ch.zone_sel;
                taken.distance_mm = sample_ch.distance_mm;
                taken.time_ms     = sample_ch.time_ms;
                expected_reports.push_back(track_sample(taken));
                accepted_count++;
            end
            if (!sample_ch.valid || sample_ch.ready)
            begin
                if (sample_queue.size() != 0 && $urandom_range(99) >= src_idle_pct)
                begin
                    taken = sample_queue.pop_front();
                    sample_ch.valid       <= 1'b1;
                    sample_ch.zone_sel    <= taken.zone_sel;
                    sample_ch.distance_mm <= taken.distance_mm;
                    sample_ch.time_ms     <= taken.time_ms;
                end
                else
                begin
                    sample_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Report monitor: checks each transfer and throttles ready, with long hold-offs on request.
    always @(posedge clk)
    begin : take_results
        result_t want;
        if (rst_n)
        begin
            if (result_ch.valid && result_ch.ready)
            begin
                report_tally[result_ch.event_code]++;
                if (expected_reports.size() == 0)
                begin
                    $error("report with nothing expected: event_code %0d, presence_report %0d",
                           result_ch.event_code, result_ch.presence_report);
                    failures++;
                end
                else
                begin
                    want = expected_reports.pop_front();
                    checked_count++;
                    if (result_ch.event_code !== want.event_code)
                    begin
                        $error("event_code mismatch: expected %0d, actual %0d",
                               want.event_code, result_ch.event_code);
                        failures++;
                    end
                    if (result_ch.presence_report !== want.presence_report)
                    begin
                        $error("presence_report mismatch: expected %0d, actual %0d",
                               want.presence_report, result_ch.presence_report);
                        failures++;
                    end
                end
            end
            if (holds_served != hold_requests)
            begin
                holds_served++;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                result_ch.ready <= 1'b0;
            end
            else
            begin
                result_ch.ready <= ($urandom_range(99) >= dst_idle_pct);
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("two_zone_direction_counter_core regression: fail");
            $finish;
        end
    end

    // One register write over the configuration channel.
    task automatic write_register(input logic [REG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
        @(posedge clk);
        cfg_ch.valid     <= 1'b1;
        cfg_ch.reg_index <= idx;
        cfg_ch.wdata     <= value;
        do @(posedge clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        case (idx)
            REG_ENTRY_MIN: zone_cfg.entry_min_mm    = value[DIST_W-1:0];
            REG_ENTRY_MAX: zone_cfg.entry_max_mm    = value[DIST_W-1:0];
            REG_EXIT_MIN:  zone_cfg.exit_min_mm     = value[DIST_W-1:0];
            REG_EXIT_MAX:  zone_cfg.exit_max_mm     = value[DIST_W-1:0];
            REG_SWAP:      zone_cfg.swap_direction  = value[0];
            REG_TIMEOUT:   zone_cfg.idle_timeout_ms = value;
            default: ;
        endcase
    endtask

    task automatic program_zones(input logic [DIST_W-1:0] en_lo, input logic [DIST_W-1:0] en_hi,
                                 input logic [DIST_W-1:0] ex_lo, input logic [DIST_W-1:0] ex_hi,
                                 input logic swap, input logic [TIME_W-1:0] limit_ms);
        write_register(REG_ENTRY_MIN, CFG_W'(en_lo));
        write_register(REG_ENTRY_MAX, CFG_W'(en_hi));
        write_register(REG_EXIT_MIN, CFG_W'(ex_lo));
        write_register(REG_EXIT_MAX, CFG_W'(ex_hi));
        write_register(REG_SWAP, CFG_W'(swap));
        write_register(REG_TIMEOUT, CFG_W'(limit_ms));
    endtask

    // Waits until every sample is through and every report is back, then lets the pipe settle.
    task automatic wait_idle();
        do @(posedge clk);
        while (sample_queue.size() != 0 || sample_ch.valid || expected_reports.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic queue_raw_sample(input logic zone, input logic [DIST_W-1:0] dist_mm);
        item_t smp;
        smp.zone_sel    = zone;
        smp.distance_mm = dist_mm;
        smp.time_ms     = now_ms;
        sample_queue.push_back(smp);
        queued_count++;
    endtask

    // A distance inside or outside the zone's bounds, hitting the bounds themselves at times.
    function automatic logic [DIST_W-1:0] pick_distance(input logic zone, input logic occupied);
        int lo_mm;
        int hi_mm;
        lo_mm = zone ? int'(zone_cfg.exit_min_mm) : int'(zone_cfg.entry_min_mm);
        hi_mm = zone ? int'(zone_cfg.exit_max_mm) : int'(zone_cfg.entry_max_mm);
        if (occupied && hi_mm - lo_mm >= 2)
        begin
            return DIST_W'($urandom_range(hi_mm - 1, lo_mm + 1));
        end
        if ($urandom_range(4) == 0)
        begin
            return DIST_W'($urandom_range(1) ? lo_mm : hi_mm);
        end
        if ($urandom_range(1))
        begin
            return DIST_W'($urandom_range(lo_mm, 0));
        end
        return DIST_W'($urandom_range(65535, hi_mm));
    endfunction

    // Time between samples: mostly inside the idle limit, now and then past it.
    function automatic logic [TIME_W-1:0] next_gap();
        if (zone_cfg.idle_timeout_ms != '0 && $urandom_range(99) < 6)
        begin
            return zone_cfg.idle_timeout_ms + TIME_W'($urandom_range(500, 1));
        end
        if (zone_cfg.idle_timeout_ms != '0 && zone_cfg.idle_timeout_ms < 40)
        begin
            return TIME_W'($urandom_range(zone_cfg.idle_timeout_ms, 0));
        end
        return TIME_W'($urandom_range(40, 0));
    endfunction

    task automatic queue_side_sample(input bit right_side, input bit occupied);
        logic zone;
        zone   = right_side ? !zone_cfg.swap_direction : zone_cfg.swap_direction;
        now_ms = now_ms + next_gap();
        queue_raw_sample(zone, pick_distance(zone, occupied));
    endtask

    // A full walk through both zones, with repeated readings between the changes.
    task automatic queue_walk(input bit outward);
        bit step_side [4];
        bit busy_now [2];
        bit pick_side;
        if (outward)
        begin
            step_side[0] = 1'b0; step_side[1] = 1'b1; step_side[2] = 1'b0; step_side[3] = 1'b1;
        end
        else
        begin
            step_side[0] = 1'b1; step_side[1] = 1'b0; step_side[2] = 1'b1; step_side[3] = 1'b0;
        end
        busy_now[0] = 1'b0;
        busy_now[1] = 1'b0;
        for (int k = 0; k < 4; k++)
        begin
            repeat ($urandom_range(2, 0))
            begin
                pick_side = $urandom_range(1);
                queue_side_sample(pick_side, busy_now[pick_side]);
            end
            queue_side_sample(step_side[k], k < 2);
            busy_now[step_side[k]] = (k < 2);
        end
    endtask

    // Mostly well-formed walks, some broken sequences, some raw noise.
    task automatic queue_random_mix(input int unsigned quota);
        int unsigned target;
        int unsigned pick;
        target = queued_count + quota;
        while (queued_count < target)
        begin
            pick = $urandom_range(99);
            if (pick < 70)
            begin
                queue_walk($urandom_range(1));
            end
            else if (pick < 85)
            begin
                repeat ($urandom_range(5, 1))
                begin
                    queue_side_sample($urandom_range(1), $urandom_range(1));
                end
            end
            else
            begin
                repeat ($urandom_range(3, 1))
                begin
                    now_ms = $urandom();
                    queue_raw_sample($urandom_range(1), DIST_W'($urandom_range(65535, 0)));
                end
                queue_side_sample(1'b0, 1'b0);
                queue_side_sample(1'b1, 1'b0);
            end
        end
    endtask

    // Reset, directed cases, then random phases over several settings.
    initial
    begin
        int lo_a;
        int lo_b;
        rst_n                 = 1'b0;
        sample_ch.valid       = 1'b0;
        sample_ch.zone_sel    = 1'b0;
        sample_ch.distance_mm = '0;
        sample_ch.time_ms     = '0;
        result_ch.ready       = 1'b0;
        cfg_ch.valid          = 1'b0;
        cfg_ch.reg_index      = REG_ENTRY_MIN;
        cfg_ch.wdata          = '0;
        zone_cfg.entry_min_mm    = '0;
        zone_cfg.entry_max_mm    = 16'hFFFF;
        zone_cfg.exit_min_mm     = '0;
        zone_cfg.exit_max_mm     = 16'hFFFF;
        zone_cfg.swap_direction  = 1'b0;
        zone_cfg.idle_timeout_ms = '0;
        reset_trail('0);
        now_ms         = 32'd5;
        queued_count   = 0;
        accepted_count = 0;
        checked_count  = 0;
        failures       = 0;
        cycle_count    = 0;
        hold_requests  = 0;
        holds_served   = 0;
        hold_left      = 0;
        src_idle_pct   = 29;
        dst_idle_pct   = 29;
        for (int k = 0; k < 4; k++)
        begin
            report_tally[k] = 0;
        end
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Reset settings: distances on the bounds are empty, one short of them occupied.
        queue_raw_sample(1'b0, 16'd0);
        queue_raw_sample(1'b0, 16'hFFFF);
        queue_raw_sample(1'b1, 16'd0);
        queue_raw_sample(1'b1, 16'hFFFF);
        // Entry walk: right, both, left, then empty.
        queue_raw_sample(1'b1, 16'hFFFE);
        queue_raw_sample(1'b0, 16'd1);
        queue_raw_sample(1'b1, 16'd0);
        queue_raw_sample(1'b0, 16'hFFFF);
        // Exit walk: left, both, right, then empty.
        queue_raw_sample(1'b0, 16'd1);
        queue_raw_sample(1'b1, 16'd1);
        queue_raw_sample(1'b0, 16'd0);
        queue_raw_sample(1'b1, 16'd0);
        // A short path, then a full path that matches neither direction.
        queue_raw_sample(1'b0, 16'd500);
        queue_raw_sample(1'b0, 16'd0);
        queue_raw_sample(1'b0, 16'd7);
        queue_raw_sample(1'b1, 16'd7);
        queue_raw_sample(1'b1, 16'hFFFF);
        queue_raw_sample(1'b0, 16'hFFFF);
        wait_idle();

        // Swapped sides and a 100 ms limit: timeout edge, then an exit across the time wrap.
        program_zones(16'd1000, 16'd2000, 16'd500, 16'd600, 1'b1, 32'd100);
        now_ms = 32'd1000;
        queue_raw_sample(1'b1, 16'd550);
        now_ms = 32'd1100;
        queue_raw_sample(1'b0, 16'd2000);
        now_ms = 32'd1101;
        queue_raw_sample(1'b0, 16'd1500);
        now_ms = 32'hFFFF_FFC0;
        queue_raw_sample(1'b0, 16'd1000);
        queue_raw_sample(1'b1, 16'd501);
        now_ms = 32'h0000_0020;
        queue_raw_sample(1'b0, 16'd1999);
        now_ms = 32'h0000_0028;
        queue_raw_sample(1'b1, 16'd600);
        now_ms = 32'h0000_0030;
        queue_raw_sample(1'b0, 16'd999);
        wait_idle();

        for (int p = 0; p < 5; p++)
        begin
            lo_a = $urandom_range(30000, 0);
            lo_b = $urandom_range(30000, 0);
            case (p)
                0: program_zones(16'd0, 16'hFFFF, 16'd0, 16'hFFFF, 1'b0, 32'd0);
                1: program_zones(16'd200, 16'd3000, 16'd150, 16'd2500, 1'b1, 32'd400);
                2: program_zones(DIST_W'(lo_a), DIST_W'(lo_a + $urandom_range(30000, 2)),
                                 16'hFFFF, 16'd0, 1'b0, 32'hFFFF_FFFF);
                3: program_zones(DIST_W'(lo_a), DIST_W'(lo_a + $urandom_range(30000, 2)),
                                 DIST_W'(lo_b), DIST_W'(lo_b + $urandom_range(30000, 2)),
                                 1'b1, 32'd1);
                default: program_zones(DIST_W'($urandom_range(65535, 0)),
                                       DIST_W'($urandom_range(65535, 0)),
                                       DIST_W'($urandom_range(65535, 0)),
                                       DIST_W'($urandom_range(65535, 0)),
                                       $urandom_range(1), TIME_W'($urandom_range(3000, 0)));
            endcase
            // The first phase runs without any idling; the second runs the sender flat out.
            src_idle_pct = (p < 2) ? 0 : 29;
            dst_idle_pct = (p == 0) ? 0 : 29;
            if (p == 3)
            begin
                now_ms = 32'hFFFF_FF00;
            end
            queue_random_mix(PHASE_ITEMS);
            if (p == 1)
            begin
                hold_requests++;
            end
            wait_idle();
        end

        repeat (8) @(posedge clk);
        if (expected_reports.size() != 0)
        begin
            $error("%0d expected reports never arrived", expected_reports.size());
            failures++;
        end
        $display("Run covered %0d samples under seven settings, %0d reports checked.",
                 accepted_count, checked_count);
        $display("Reports seen: %0d entries, %0d exits, %0d timeouts, %0d without a direction.",
                 report_tally[EV_ENTRY], report_tally[EV_EXIT], report_tally[EV_TIMEOUT],
                 report_tally[EV_NONE]);
        if (failures == 0)
        begin
            $display("two_zone_direction_counter_core regression: pass");
        end
        else
        begin
            $display("two_zone_direction_counter_core regression: fail");
        end
        $finish;
    end

endmodule
